>>> hw/rtl/lbps_pkg.sv
// Package for the LED blink pattern sequencer.
// Holds widths, tick thresholds, item and mode codes and the sequencer state type.
// It has no dependencies.
package lbps_pkg;

  localparam int TICK_MS = 20;
  localparam int DATA_W  = 16;
  localparam int MODE_W  = 5;
  localparam int KIND_W  = 2;
  localparam int STEP_W  = $clog2(DATA_W);
  localparam int R640_W  = $clog2(640 / TICK_MS);

  localparam logic [DATA_W-1:0] T100  = DATA_W'(100 / TICK_MS);
  localparam logic [DATA_W-1:0] T200  = DATA_W'(200 / TICK_MS);
  localparam logic [DATA_W-1:0] T300  = DATA_W'(300 / TICK_MS);
  localparam logic [DATA_W-1:0] T400  = DATA_W'(400 / TICK_MS);
  localparam logic [DATA_W-1:0] T500  = DATA_W'(500 / TICK_MS);
  localparam logic [DATA_W-1:0] T600  = DATA_W'(600 / TICK_MS);
  localparam logic [DATA_W-1:0] T320  = DATA_W'(320 / TICK_MS);
  localparam logic [DATA_W-1:0] T640  = DATA_W'(640 / TICK_MS);
  localparam logic [DATA_W-1:0] T1000 = DATA_W'(1000 / TICK_MS);
  localparam logic [DATA_W-1:0] T1280 = DATA_W'(1280 / TICK_MS);
  localparam logic [DATA_W-1:0] T3000 = DATA_W'(3000 / TICK_MS);

  localparam logic [KIND_W-1:0] KIND_TICK        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_MODE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START_FLASH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NORMAL           = 5'd0;
  localparam logic [MODE_W-1:0] MODE_TEST_BLE_OK      = 5'd1;
  localparam logic [MODE_W-1:0] MODE_CONFIG           = 5'd2;
  localparam logic [MODE_W-1:0] MODE_BTN_RESET_3S     = 5'd3;
  localparam logic [MODE_W-1:0] MODE_BTN_PRESS_NORMAL = 5'd4;
  localparam logic [MODE_W-1:0] MODE_BTN_RESET_10S    = 5'd5;
  localparam logic [MODE_W-1:0] MODE_BTN_PRESS_CFG    = 5'd6;
  localparam logic [MODE_W-1:0] MODE_PAIR_DOING       = 5'd7;
  localparam logic [MODE_W-1:0] MODE_PAIR_SUCCESS     = 5'd8;
  localparam logic [MODE_W-1:0] MODE_PAIR_FAILED      = 5'd9;
  localparam logic [MODE_W-1:0] MODE_PROV_DOING       = 5'd10;
  localparam logic [MODE_W-1:0] MODE_PROV_DONE        = 5'd11;
  localparam logic [MODE_W-1:0] MODE_FLASH            = 5'd12;
  localparam logic [MODE_W-1:0] MODE_LOW_POWER        = 5'd13;
  localparam logic [MODE_W-1:0] MODE_TEST_DOING       = 5'd14;
  localparam logic [MODE_W-1:0] MODE_TEST_UPGRADE_OK  = 5'd15;
  localparam logic [MODE_W-1:0] MODE_TEST_BLE_FAILED  = 5'd16;
  localparam logic [MODE_W-1:0] MODE_TEST_MODE_FAILED = 5'd17;
  localparam logic [MODE_W-1:0] MODE_TEST_DID_FAILED  = 5'd18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/led_blink_pattern_sequencer.sv
// Top level of the two-LED blink pattern sequencer with its shared add/subtract unit.
// Depends on lbps_pkg for widths, thresholds, codes and the state type.
//
// Each input transfer produces exactly one result transfer carrying the LED levels and the
// display mode after the item. A set-mode item or an unused kind goes straight to the done
// state, and a tick that needs no remainder passes through the apply state first. Ticks that
// need a remainder run a divide pass before the apply state: the periodic modes, provision
// done before its timeout and a running flash. The "test BLE failed" mode runs two divide
// passes, and a start-flash item runs a multiply pass. Both passes use one 18-bit add/subtract
// unit that runs a restoring remainder or a shift-add product one bit per cycle.
// The input is stalled until the result is loaded into the output register; a pending
// result does not block the next item until that item's own result is ready.
module led_blink_pattern_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lbps_pkg::KIND_W-1:0]    in_kind,
  input  logic [lbps_pkg::MODE_W-1:0]    in_new_mode,
  input  logic                           in_provisioned,
  input  logic [lbps_pkg::DATA_W-1:0]    in_flash_cycle_arg,
  input  logic [lbps_pkg::DATA_W-1:0]    in_flash_times,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_blue_led,
  output logic                           out_yellow_led,
  output logic [lbps_pkg::MODE_W-1:0]    out_mode_now
);
  import lbps_pkg::*;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   active_r, active_nxt;
  logic [MODE_W-1:0]   prev_r, prev_nxt;
  logic [DATA_W-1:0]   tick_r, tick_nxt;
  logic [DATA_W-1:0]   cycle_r, cycle_nxt;
  logic [DATA_W-1:0]   span_r, span_nxt;
  logic                blue_r, blue_nxt;
  logic                yellow_r, yellow_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_blue_r, out_blue_nxt;
  logic                out_yellow_r, out_yellow_nxt;
  logic [MODE_W-1:0]   out_mode_r, out_mode_nxt;

  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   dvd_r, dvd_nxt;
  logic [DATA_W-1:0]   opb_r, opb_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [R640_W-1:0]   save_r, save_nxt;
  logic                prov_r, prov_nxt;
  logic                pass_r, pass_nxt;

  logic                is_mul;
  logic                alu_sub;
  logic [DATA_W+1:0]   alu_a;
  logic [DATA_W+1:0]   alu_b;
  logic [DATA_W+1:0]   alu_sum;
  logic [DATA_W-1:0]   step_rem;
  logic [DATA_W-1:0]   tc_w;
  logic [DATA_W-1:0]   divisor_w;
  logic [DATA_W-1:0]   half_cycle;
  logic                expire_acc;
  logic                expire_app;
  logic                need_div;
  logic                last_step;
  logic                blue_first;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_blue_led   = out_blue_r;
  assign out_yellow_led = out_yellow_r;
  assign out_mode_now   = out_mode_r;

  // Shared unit: restoring remainder step when dividing, shift-add step when multiplying.
  assign is_mul   = (state_r == ST_MUL);
  assign alu_sub  = !is_mul;
  assign alu_a    = is_mul ? {2'b00, rem_r[DATA_W-2:0], 1'b0}
                           : {1'b0, rem_r, dvd_r[DATA_W-1]};
  assign alu_b    = {2'b00, (is_mul && !dvd_r[DATA_W-1]) ? {DATA_W{1'b0}} : opb_r};
  assign alu_sum  = alu_a + (alu_b ^ {(DATA_W+2){alu_sub}})
                    + {{(DATA_W+1){1'b0}}, alu_sub};
  assign step_rem = (alu_sub && alu_sum[DATA_W+1]) ? alu_a[DATA_W-1:0]
                                                   : alu_sum[DATA_W-1:0];
  assign last_step = (cnt_r == STEP_W'(DATA_W - 1));

  assign tc_w       = (prev_r != active_r) ? '0 : tick_r + DATA_W'(1);
  assign expire_acc = (tc_w > span_r) || (span_r == '0) || (cycle_r == '0);
  assign expire_app = (tick_r > span_r) || (span_r == '0) || (cycle_r == '0);
  assign half_cycle = cycle_r >> 1;
  assign blue_first = (active_r == MODE_TEST_MODE_FAILED);

  always_comb begin
    case (active_r)
      MODE_BTN_PRESS_NORMAL, MODE_BTN_RESET_10S, MODE_BTN_PRESS_CFG: divisor_w = T200;
      MODE_FLASH:                                                   divisor_w = cycle_r;
      MODE_LOW_POWER, MODE_TEST_UPGRADE_OK:                         divisor_w = T1000;
      MODE_TEST_MODE_FAILED, MODE_TEST_DID_FAILED:                  divisor_w = T3000;
      default:                                                      divisor_w = T640;
    endcase
    need_div = (active_r inside {MODE_BTN_PRESS_NORMAL, MODE_BTN_RESET_10S,
                                 MODE_BTN_PRESS_CFG, MODE_PROV_DOING, MODE_LOW_POWER,
                                 MODE_TEST_UPGRADE_OK, MODE_TEST_BLE_FAILED,
                                 MODE_TEST_MODE_FAILED, MODE_TEST_DID_FAILED})
               || ((active_r == MODE_PROV_DONE) && (tc_w < T3000))
               || ((active_r == MODE_FLASH) && !expire_acc);
  end

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    prev_nxt       = prev_r;
    tick_nxt       = tick_r;
    cycle_nxt      = cycle_r;
    span_nxt       = span_r;
    blue_nxt       = blue_r;
    yellow_nxt     = yellow_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    opb_nxt        = opb_r;
    cnt_nxt        = cnt_r;
    save_nxt       = save_r;
    prov_nxt       = prov_r;
    pass_nxt       = pass_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_blue_nxt   = out_blue_r;
    out_yellow_nxt = out_yellow_r;
    out_mode_nxt   = out_mode_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          prov_nxt = in_provisioned;
          pass_nxt = 1'b0;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          case (in_kind)
            KIND_TICK: begin
              prev_nxt  = active_r;
              tick_nxt  = tc_w;
              dvd_nxt   = tc_w;
              opb_nxt   = divisor_w;
              state_nxt = need_div ? ST_DIV : ST_APPLY;
            end
            KIND_SET_MODE: begin
              active_nxt = in_new_mode;
              state_nxt  = ST_DONE;
            end
            KIND_START_FLASH: begin
              cycle_nxt  = in_flash_cycle_arg >> 1;
              opb_nxt    = in_flash_cycle_arg >> 1;
              dvd_nxt    = in_flash_times;
              active_nxt = MODE_FLASH;
              tick_nxt   = '0;
              state_nxt  = ST_MUL;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL, ST_DIV: begin
        rem_nxt = step_rem;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + STEP_W'(1);
        if (last_step) begin
          if (is_mul) begin
            span_nxt  = step_rem;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        state_nxt = ST_DONE;
        case (active_r)
          MODE_NORMAL, MODE_TEST_BLE_OK: begin
            blue_nxt   = 1'b0;
            yellow_nxt = 1'b0;
            tick_nxt   = '0;
          end
          MODE_CONFIG: begin
            blue_nxt   = prov_r;
            yellow_nxt = !prov_r;
            tick_nxt   = '0;
          end
          MODE_BTN_RESET_3S: begin
            blue_nxt   = prov_r;
            yellow_nxt = !prov_r;
          end
          MODE_BTN_PRESS_NORMAL: begin
            if (tick_r == DATA_W'(1)) begin
              if (prov_r) blue_nxt = 1'b1;
              else yellow_nxt = 1'b1;
            end else if (tick_r == T100) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end
            tick_nxt = rem_r;
          end
          MODE_BTN_RESET_10S, MODE_BTN_PRESS_CFG: begin
            if (tick_r == DATA_W'(1)) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end else if (tick_r == T100) begin
              if (prov_r) blue_nxt = 1'b1;
              else yellow_nxt = 1'b1;
            end
            tick_nxt = rem_r;
          end
          MODE_PAIR_DOING: begin
            if (tick_r == DATA_W'(1) || tick_r == T400) begin
              if (prov_r) blue_nxt = 1'b1;
              else yellow_nxt = 1'b1;
            end else if (tick_r == T200 || tick_r == T600) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end else if (tick_r == T3000) begin
              tick_nxt = '0;
            end
          end
          MODE_PAIR_SUCCESS, MODE_PAIR_FAILED: begin
            blue_nxt   = 1'b0;
            yellow_nxt = 1'b1;
          end
          MODE_PROV_DOING, MODE_PROV_DONE: begin
            if (active_r == MODE_PROV_DONE && tick_r >= T3000) begin
              active_nxt = MODE_NORMAL;
              blue_nxt   = 1'b1;
              yellow_nxt = 1'b0;
              tick_nxt   = '0;
            end else begin
              if (rem_r == DATA_W'(1)) begin
                blue_nxt   = 1'b0;
                yellow_nxt = 1'b1;
              end else if (rem_r == T320) begin
                blue_nxt   = 1'b1;
                yellow_nxt = 1'b0;
              end
              if (active_r == MODE_PROV_DOING) tick_nxt = rem_r;
            end
          end
          MODE_FLASH: begin
            if (expire_app) begin
              span_nxt   = '0;
              cycle_nxt  = '0;
              tick_nxt   = '0;
              active_nxt = MODE_NORMAL;
            end else if (rem_r == DATA_W'(1)) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end else if (rem_r == half_cycle) begin
              if (prov_r) blue_nxt = 1'b1;
              else yellow_nxt = 1'b1;
            end
          end
          MODE_LOW_POWER: begin
            if (rem_r == DATA_W'(1)) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b1;
            end else if (rem_r == T100) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end
            tick_nxt = rem_r;
          end
          MODE_TEST_DOING: begin
            blue_nxt   = 1'b1;
            yellow_nxt = 1'b0;
          end
          MODE_TEST_UPGRADE_OK: begin
            if (rem_r == DATA_W'(1)) begin
              blue_nxt   = 1'b1;
              yellow_nxt = 1'b0;
            end else if (rem_r == T100) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end
            tick_nxt = rem_r;
          end
          MODE_TEST_BLE_FAILED: begin
            if (!pass_r) begin
              save_nxt  = rem_r[R640_W-1:0];
              pass_nxt  = 1'b1;
              dvd_nxt   = tick_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              opb_nxt   = T1280;
              state_nxt = ST_DIV;
            end else begin
              if (DATA_W'(save_r) == DATA_W'(1)) begin
                blue_nxt   = 1'b0;
                yellow_nxt = 1'b1;
              end else if (DATA_W'(save_r) == T320) begin
                blue_nxt   = 1'b1;
                yellow_nxt = 1'b0;
              end
              tick_nxt = rem_r;
            end
          end
          MODE_TEST_MODE_FAILED, MODE_TEST_DID_FAILED: begin
            if (rem_r == DATA_W'(1) || rem_r == T200) begin
              blue_nxt   = blue_first;
              yellow_nxt = !blue_first;
            end else if (rem_r == T100 || rem_r == T300) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end else if (rem_r == T400) begin
              blue_nxt   = !blue_first;
              yellow_nxt = blue_first;
            end else if (rem_r == T500) begin
              blue_nxt   = 1'b0;
              yellow_nxt = 1'b0;
            end
            tick_nxt = rem_r;
          end
          default: begin
            tick_nxt   = '0;
            active_nxt = MODE_NORMAL;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_blue_nxt   = blue_r;
          out_yellow_nxt = yellow_r;
          out_mode_nxt   = active_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= MODE_NORMAL;
      prev_r      <= MODE_NORMAL;
      tick_r      <= '0;
      cycle_r     <= '0;
      span_r      <= '0;
      blue_r      <= 1'b0;
      yellow_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      prev_r      <= prev_nxt;
      tick_r      <= tick_nxt;
      cycle_r     <= cycle_nxt;
      span_r      <= span_nxt;
      blue_r      <= blue_nxt;
      yellow_r    <= yellow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    opb_r        <= opb_nxt;
    cnt_r        <= cnt_nxt;
    save_r       <= save_nxt;
    prov_r       <= prov_nxt;
    pass_r       <= pass_nxt;
    out_blue_r   <= out_blue_nxt;
    out_yellow_r <= out_yellow_nxt;
    out_mode_r   <= out_mode_nxt;
  end

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (opb_r != '0))
    else $error("divide pass started with a zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY && $past(state_r) == ST_DIV) |-> (rem_r < opb_r))
    else $error("remainder not below divisor after divide pass");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result became valid outside the done state");

  a_second_pass_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY && pass_r) |-> (active_r == MODE_TEST_BLE_FAILED))
    else $error("second divide pass in a mode that needs only one");
`endif

endmodule
